>>> hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int URG_W        = 4;

    // Operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_DEQUEUED = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] payload;
        logic [URG_W-1:0]         urgency;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] head_data;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming command
        logic exec;   // run compare and shift, update the result register
    } t_dp_ctrl;

endpackage

>>> hdl/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output spq_pkg::t_dp_ctrl o_ctrl
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done,  n_done;

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_done      = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

>>> hdl/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_dp_ctrl i_ctrl,
    input  spq_pkg::t_cmd     i_cmd,
    output spq_pkg::t_result  o_result
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_slot_data [CAPACITY];
    logic signed [DATA_W-1:0] n_slot_data [CAPACITY];
    logic [URG_W-1:0]         r_slot_urg  [CAPACITY];
    logic [URG_W-1:0]         n_slot_urg  [CAPACITY];
    logic [OCC_W-1:0]         r_occ, n_occ;
    t_result                  r_result, n_result;

    logic [CAPACITY-1:0] keep;
    logic                full;
    logic                empty;

    // A slot stays put when it is occupied and at least as urgent as the new entry.
    // The list is sorted, so these flags form a prefix.
    always_comb begin
        full  = (r_occ == OCC_W'(CAPACITY));
        empty = (r_occ == '0);
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (OCC_W'(i) < r_occ) && (r_slot_urg[i] <= r_cmd.urgency);
        end
    end

    always_comb begin
        n_slot_data = r_slot_data;
        n_slot_urg  = r_slot_urg;
        n_occ       = r_occ;
        n_result    = r_result;
        if (i_ctrl.exec) begin
            n_result.head_data = '0;
            if (r_cmd.operation == OP_ENQUEUE) begin
                if (full) begin
                    n_result.status = STAT_FULL;
                end else begin
                    n_result.status = STAT_ENQUEUED;
                    n_occ           = r_occ + OCC_W'(1);
                    if (!keep[0]) begin
                        n_slot_data[0] = r_cmd.payload;
                        n_slot_urg[0]  = r_cmd.urgency;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (!keep[i]) begin
                            if (keep[i-1]) begin
                                n_slot_data[i] = r_cmd.payload;
                                n_slot_urg[i]  = r_cmd.urgency;
                            end else begin
                                n_slot_data[i] = r_slot_data[i-1];
                                n_slot_urg[i]  = r_slot_urg[i-1];
                            end
                        end
                    end
                end
            end else begin
                if (empty) begin
                    n_result.status = STAT_EMPTY;
                end else begin
                    n_result.status    = STAT_DEQUEUED;
                    n_result.head_data = r_slot_data[0];
                    n_occ              = r_occ - OCC_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_slot_data[i] = r_slot_data[i+1];
                        n_slot_urg[i]  = r_slot_urg[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
        end
        r_slot_data <= n_slot_data;
        r_slot_urg  <= n_slot_urg;
        r_result    <= n_result;
    end

    assign o_result = r_result;

endmodule

>>> hdl/stable_priority_queue_core.sv
`timescale 1ns / 1ps

// A command transferred in idle is captured in the command register; the exec state then
//   runs compare and shift and loads the result and done registers together.
// A new command is taken only back in idle; busy is high for the one compare-and-shift cycle.
// Every command yields one result; the receiver cannot stall, so o_done is a one-cycle strobe.
// Reset (synchronous, active low) empties the queue and returns the controller to idle.
module stable_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  spq_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output spq_pkg::t_result o_result
);
    import spq_pkg::*;

    t_dp_ctrl dp_ctrl;

    // Controller: idle -> exec -> idle, one transfer per pass
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctrl  (dp_ctrl)
    );

    // Datapath: sorted slot registers, parallel compare and one-step shift
    // for insert (toward the tail) or removal (toward the head)
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dp_ctrl),
        .i_cmd    (i_cmd),
        .o_result (o_result)
    );

endmodule

>>> hdl/spq_checker.sv
`timescale 1ns / 1ps

module spq_assertions (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input spq_pkg::t_result o_result
);
    import spq_pkg::*;

    // Every transfer yields a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing after transfer");

    // Busy lasts a single cycle
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work cycle");

    // Data is zero unless an entry was removed
    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != STAT_DEQUEUED)) |-> (o_result.head_data == '0))
        else $error("nonzero data on a non-dequeue result");

endmodule

bind stable_priority_queue_core spq_assertions u_spq_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
